[design/deq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

	// Widths of the result fields
	localparam int unsigned OUT_BITS   = 32;
	localparam int unsigned COUNT_BITS = 5;

	// Action codes carried by each input beat; unused codes act as none
	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_REAR  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_REAR   = 3'd3,
		ACT_CLEAR      = 3'd4,
		ACT_NONE       = 3'd5
	} action_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

endpackage
`default_nettype wire

[design/double_ended_queue.sv]
// Bounded double-ended queue of DEPTH words held in a ring store. Each input beat carries one
// action (push front, push rear, pop front, pop rear, clear or none; codes 6 and 7 act as none)
// and yields exactly one result beat: front and rear words (-1 when empty, sign-extended from
// WORD_BITS), the count, and empty, underflow and overflow flags. A push into a full queue is
// dropped and flagged, a pop from an empty one changes nothing and is flagged. Each item passes
// through the sequencer states in turn: on acceptance in IDLE the action updates the pointers and
// writes the store, READ reads the front and rear entries from the registered word store, and LOAD
// loads the result register once the output is free. A new beat is taken while the previous result
// still waits at the output. No clearing pass follows reset: only occupied entries are ever shown.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue #(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned WORD_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [2:0]                           action,
	input  wire logic signed [deq_pkg::OUT_BITS-1:0]  value,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [deq_pkg::OUT_BITS-1:0]       front_value,
	output logic signed [deq_pkg::OUT_BITS-1:0]       rear_value,
	output logic [deq_pkg::COUNT_BITS-1:0]            count,
	output logic                                      empty_res,
	output logic                                      underflow,
	output logic                                      overflow
);

	localparam int unsigned PTR_BITS = $clog2(DEPTH);
	localparam int unsigned OCC_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
	localparam logic [OCC_BITS-1:0] OCC_FULL = OCC_BITS'(DEPTH);

	deq_pkg::state_t state_q, state_d;

	logic [PTR_BITS-1:0] front_q, rear_q;
	logic [OCC_BITS-1:0] occ_q;
	logic                under_q, over_q;

	logic [PTR_BITS-1:0] front_d, rear_d, wr_addr, rear_last;
	logic [OCC_BITS-1:0] occ_d;
	logic                under_d, over_d, wr_en;
	logic                accept, rd_en, out_load;
	logic                is_full, is_empty;

	logic [WORD_BITS-1:0] wr_data, rd_front, rd_rear;
	logic [63:0]          front_ext, rear_ext;

	// Pointer step helpers with wrap at DEPTH
	function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_BITS-1:0] ptr_dec(input logic [PTR_BITS-1:0] p);
		return (p == '0) ? PTR_LAST : p - 1'b1;
	endfunction

	assign accept    = in_valid & in_ready;
	assign is_full   = (occ_q == OCC_FULL);
	assign is_empty  = (occ_q == '0);
	assign wr_data   = WORD_BITS'(value);
	assign rear_last = ptr_dec(rear_q);

	// Decode the action into new pointers, count, store write and flags
	always_comb begin
		front_d = front_q;
		rear_d  = rear_q;
		occ_d   = occ_q;
		wr_en   = 1'b0;
		wr_addr = rear_q;
		under_d = 1'b0;
		over_d  = 1'b0;
		unique case (deq_pkg::action_t'(action))
			deq_pkg::ACT_PUSH_FRONT: begin
				if (is_full) begin
					over_d = 1'b1;
				end else begin
					front_d = ptr_dec(front_q);
					wr_addr = ptr_dec(front_q);
					wr_en   = accept;
					occ_d   = occ_q + 1'b1;
				end
			end
			deq_pkg::ACT_PUSH_REAR: begin
				if (is_full) begin
					over_d = 1'b1;
				end else begin
					wr_en  = accept;
					rear_d = ptr_inc(rear_q);
					occ_d  = occ_q + 1'b1;
				end
			end
			deq_pkg::ACT_POP_FRONT: begin
				if (is_empty) begin
					under_d = 1'b1;
				end else begin
					front_d = ptr_inc(front_q);
					occ_d   = occ_q - 1'b1;
				end
			end
			deq_pkg::ACT_POP_REAR: begin
				if (is_empty) begin
					under_d = 1'b1;
				end else begin
					rear_d = rear_last;
					occ_d  = occ_q - 1'b1;
				end
			end
			deq_pkg::ACT_CLEAR: begin
				front_d = '0;
				rear_d  = '0;
				occ_d   = '0;
			end
			default: begin
			end
		endcase
	end

	// Advance the sequencer
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = deq_pkg::ST_READ;
				end
			end
			deq_pkg::ST_READ: begin
				rd_en   = 1'b1;
				state_d = deq_pkg::ST_LOAD;
			end
			deq_pkg::ST_LOAD: begin
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					state_d  = deq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = deq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold pointers and count; update them on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			occ_q   <= '0;
		end else if (accept) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			occ_q   <= occ_d;
		end
	end

	// Hold the flags of the beat in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			under_q <= under_d;
			over_q  <= over_d;
		end
	end

	deq_ram #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (front_q),
		.rd_addr_b (rear_last),
		.rd_data_a (rd_front),
		.rd_data_b (rd_rear)
	);

	// Sign-extend stored words to the result width
	assign front_ext = 64'($signed(rd_front));
	assign rear_ext  = 64'($signed(rd_rear));

	// Output valid: set on load, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (out_load) begin
			front_value <= is_empty ? '1 : front_ext[deq_pkg::OUT_BITS-1:0];
			rear_value  <= is_empty ? '1 : rear_ext[deq_pkg::OUT_BITS-1:0];
			count       <= deq_pkg::COUNT_BITS'(occ_q);
			empty_res   <= is_empty;
			underflow   <= under_q;
			overflow    <= over_q;
		end
	end

	// Ring consistency: rear sits count places past front, modulo DEPTH
	logic [OCC_BITS:0] ptr_sum;
	logic [OCC_BITS:0] ptr_wrap;
	assign ptr_sum  = (OCC_BITS + 1)'(front_q) + (OCC_BITS + 1)'(occ_q);
	assign ptr_wrap = (ptr_sum >= (OCC_BITS + 1)'(DEPTH)) ? ptr_sum - (OCC_BITS + 1)'(DEPTH)
		: ptr_sum;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("occupancy beyond depth");

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_wrap == (OCC_BITS + 1)'(rear_q))
		else $error("rear pointer out of step with front and count");

	a_load_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> $past(state_q == deq_pkg::ST_READ) || $past(state_q == deq_pkg::ST_LOAD))
		else $error("result loaded without a store read");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(underflow && overflow))
		else $error("underflow and overflow raised together");

endmodule
`default_nettype wire

[design/deq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module deq_ram #(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned WORD_BITS = 32,
	localparam int unsigned PTR_BITS = $clog2(DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [PTR_BITS-1:0]  wr_addr,
	input  wire logic [WORD_BITS-1:0] wr_data,
	input  wire logic                 rd_en,
	input  wire logic [PTR_BITS-1:0]  rd_addr_a,
	input  wire logic [PTR_BITS-1:0]  rd_addr_b,
	output logic      [WORD_BITS-1:0] rd_data_a,
	output logic      [WORD_BITS-1:0] rd_data_b
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	// Write one word per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read two words with registered data; hold the data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule
`default_nettype wire

[tb/tb_double_ended_queue.sv]
`timescale 1ns / 1ps
module tb_double_ended_queue;

	localparam int unsigned DEPTH         = 16;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned DRAIN_CYCLES  = 12;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned PRINT_LIMIT   = 30;
	localparam logic [2:0]  ACT_SPARE_LO  = 3'd6;
	localparam logic [2:0]  ACT_SPARE_HI  = 3'd7;
	localparam logic signed [31:0] WORD_MIN   = 32'sh8000_0000;
	localparam logic signed [31:0] WORD_MAX   = 32'sh7fff_ffff;
	localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

	typedef struct packed {
		logic [2:0]          act;
		logic signed [31:0]  word;
	} beat_t;

	typedef struct packed {
		logic signed [31:0]  front;
		logic signed [31:0]  rear;
		logic [4:0]          cnt;
		logic                empty;
		logic                under;
		logic                over;
	} deq_view_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [2:0]          action    = deq_pkg::ACT_NONE;
	logic signed [31:0]  value     = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic signed [31:0]  front_value;
	logic signed [31:0]  rear_value;
	logic [4:0]          count;
	logic                empty_res;
	logic                underflow;
	logic                overflow;

	double_ended_queue u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.front_value (front_value),
		.rear_value  (rear_value),
		.count       (count),
		.empty_res   (empty_res),
		.underflow   (underflow),
		.overflow    (overflow)
	);

	// Shadow copy of the deque contents
	logic signed [31:0]  shadow_words [DEPTH];
	int unsigned         shadow_front = 0;
	int unsigned         shadow_rear  = 0;
	int unsigned         shadow_occ   = 0;

	beat_t               pending_beats [$];
	deq_view_t           expected_views [$];
	beat_t               next_beat;
	int unsigned         plan_occ       = 0;
	int unsigned         send_idle_pct  = 0;
	int unsigned         recv_stall_pct = 0;
	logic                hold_req       = 1'b0;
	logic                hold_off       = 1'b0;
	int unsigned         cycle_cnt      = 0;
	int unsigned         n_items        = 0;
	int unsigned         n_results      = 0;
	int unsigned         n_errors       = 0;
	int unsigned         n_over         = 0;
	int unsigned         n_under        = 0;

	always #1 clk = ~clk;

	// Apply one action to the shadow deque and return the view it leaves
	function automatic deq_view_t deq_apply(logic [2:0] act, logic signed [31:0] word);
		deq_view_t r;
		r = '0;
		case (act)
		deq_pkg::ACT_PUSH_FRONT: begin
			if (shadow_occ >= DEPTH) begin
				r.over = 1'b1;
			end else begin
				shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
				shadow_words[shadow_front] = word;
				shadow_occ++;
			end
		end
		deq_pkg::ACT_PUSH_REAR: begin
			if (shadow_occ >= DEPTH) begin
				r.over = 1'b1;
			end else begin
				shadow_words[shadow_rear] = word;
				shadow_rear = (shadow_rear + 1) % DEPTH;
				shadow_occ++;
			end
		end
		deq_pkg::ACT_POP_FRONT: begin
			if (shadow_occ == 0) begin
				r.under = 1'b1;
			end else begin
				shadow_front = (shadow_front + 1) % DEPTH;
				shadow_occ--;
			end
		end
		deq_pkg::ACT_POP_REAR: begin
			if (shadow_occ == 0) begin
				r.under = 1'b1;
			end else begin
				shadow_rear = (shadow_rear + DEPTH - 1) % DEPTH;
				shadow_occ--;
			end
		end
		deq_pkg::ACT_CLEAR: begin
			shadow_front = 0;
			shadow_rear  = 0;
			shadow_occ   = 0;
		end
		default: ;
		endcase
		if (shadow_occ == 0) begin
			r.front = EMPTY_WORD;
			r.rear  = EMPTY_WORD;
		end else begin
			r.front = shadow_words[shadow_front];
			r.rear  = shadow_words[(shadow_rear + DEPTH - 1) % DEPTH];
		end
		r.cnt   = 5'(shadow_occ);
		r.empty = (shadow_occ == 0);
		n_over  += r.over;
		n_under += r.under;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (n_errors < PRINT_LIMIT)
			$display("mismatch at result %0d: %s got %h want %h", n_results, field, got, want);
		n_errors++;
	endtask

	task automatic check_result();
		deq_view_t want;
		if (expected_views.size() == 0) begin
			report_mismatch("result beat with nothing outstanding", '0, '0);
			return;
		end
		want = expected_views.pop_front();
		n_results++;
		if (front_value !== want.front) report_mismatch("front_value", front_value, want.front);
		if (rear_value !== want.rear)   report_mismatch("rear_value", rear_value, want.rear);
		if (count !== want.cnt)         report_mismatch("count", 32'(count), 32'(want.cnt));
		if (empty_res !== want.empty)   report_mismatch("empty_res", 32'(empty_res), 32'(want.empty));
		if (underflow !== want.under)   report_mismatch("underflow", 32'(underflow), 32'(want.under));
		if (overflow !== want.over)     report_mismatch("overflow", 32'(overflow), 32'(want.over));
	endtask

	// Queue one beat and track the occupancy it will leave behind
	task automatic queue_beat(logic [2:0] act, logic signed [31:0] word);
		beat_t b;
		b.act  = act;
		b.word = word;
		pending_beats.push_back(b);
		case (act)
		deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR: if (plan_occ < DEPTH) plan_occ++;
		deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_REAR:   if (plan_occ > 0) plan_occ--;
		deq_pkg::ACT_CLEAR:                              plan_occ = 0;
		default: ;
		endcase
		n_items++;
	endtask

	// Favour the extremes and the all-ones word that mimics an empty deque
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 7))
		0:       return WORD_MIN;
		1:       return WORD_MAX;
		2:       return EMPTY_WORD;
		3:       return '0;
		default: return $urandom;
		endcase
	endfunction

	// Mostly fill and drain bursts that hit the full and empty corners, with noise between
	task automatic add_random(int unsigned n);
		int unsigned start;
		int unsigned len;
		int unsigned kind;
		start = n_items;
		kind  = 0;
		while (n_items - start < n) begin
			case (kind)
			0, 1, 2: begin
				len = DEPTH - plan_occ + $urandom_range(0, 2);
				repeat (len)
					queue_beat($urandom_range(0, 1) ? deq_pkg::ACT_PUSH_FRONT
						: deq_pkg::ACT_PUSH_REAR, pick_word());
			end
			3, 4: begin
				len = plan_occ + $urandom_range(0, 2);
				repeat (len)
					queue_beat($urandom_range(0, 1) ? deq_pkg::ACT_POP_FRONT
						: deq_pkg::ACT_POP_REAR, pick_word());
			end
			5: queue_beat(deq_pkg::ACT_CLEAR, pick_word());
			default: begin
				repeat ($urandom_range(1, 8))
					queue_beat(3'($urandom_range(0, 7)), pick_word());
			end
			endcase
			kind = $urandom_range(0, 9);
		end
	endtask

	// Hold the sender back until every outstanding result has come out
	task automatic wait_drained();
		while (pending_beats.size() != 0 || in_valid || expected_views.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Drive input beats from the pending queue; predict on every accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_views.push_back(deq_apply(action, value));
			if (!in_valid || in_ready) begin
				if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_beat = pending_beats.pop_front();
					in_valid  <= 1'b1;
					action    <= next_beat.act;
					value     <= next_beat.word;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check result beats and stall the output at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Hold off the receiver for a long stretch so the block backs up
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("double_ended_queue regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty corners, spare codes, both ends, pointer wrap below zero, clear
		queue_beat(deq_pkg::ACT_POP_FRONT, WORD_MAX);
		queue_beat(deq_pkg::ACT_POP_REAR, WORD_MIN);
		queue_beat(deq_pkg::ACT_NONE, EMPTY_WORD);
		queue_beat(ACT_SPARE_LO, '0);
		queue_beat(deq_pkg::ACT_CLEAR, WORD_MAX);
		queue_beat(deq_pkg::ACT_PUSH_FRONT, WORD_MIN);
		queue_beat(deq_pkg::ACT_PUSH_REAR, WORD_MAX);
		queue_beat(deq_pkg::ACT_PUSH_FRONT, EMPTY_WORD);
		queue_beat(deq_pkg::ACT_PUSH_REAR, '0);
		queue_beat(ACT_SPARE_HI, WORD_MIN);
		queue_beat(deq_pkg::ACT_NONE, WORD_MAX);
		queue_beat(deq_pkg::ACT_POP_FRONT, '0);
		queue_beat(deq_pkg::ACT_POP_REAR, '0);
		queue_beat(deq_pkg::ACT_POP_FRONT, '0);
		queue_beat(deq_pkg::ACT_POP_REAR, '0);
		queue_beat(deq_pkg::ACT_POP_REAR, '0);
		queue_beat(deq_pkg::ACT_PUSH_REAR, 32'sh5555_5555);
		queue_beat(deq_pkg::ACT_PUSH_FRONT, 32'shaaaa_aaaa);
		queue_beat(deq_pkg::ACT_CLEAR, '0);
		queue_beat(deq_pkg::ACT_POP_FRONT, '0);

		// Free-running, no idling on either side
		add_random(460);
		wait_drained();

		// Sparse sender
		send_idle_pct  = 79;
		recv_stall_pct = 0;
		add_random(460);
		wait_drained();

		// Slow receiver
		send_idle_pct  = 0;
		recv_stall_pct = 79;
		add_random(460);
		wait_drained();

		// Both sides idling
		send_idle_pct  = 32;
		recv_stall_pct = 32;
		add_random(460);
		wait_drained();

		// Back-pressure: receiver held off while the sender keeps offering
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		add_random(150);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d actions and %0d results, %0d overflows, %0d underflows",
			n_items, n_results, n_over, n_under);
		$display("over free-running, sparse-sender, slow-receiver, mixed and held-off phases");
		if (n_errors == 0) begin
			$display("double_ended_queue regression: pass");
		end else begin
			$display("double_ended_queue regression: fail");
		end
		$finish;
	end

endmodule

[double_ended_queue.f]
design/deq_pkg.sv
design/deq_ram.sv
design/double_ended_queue.sv
tb/tb_double_ended_queue.sv
